FILE: hdl/bresenham_line_pixels_assert.svh
// Assertion macros for the line pixel generator.
// Assumes clk and arst_n are visible where the macros are used.
`ifndef BRESENHAM_LINE_PIXELS_ASSERT_SVH
`define BRESENHAM_LINE_PIXELS_ASSERT_SVH

// same-cycle implication
`define BLP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bresln_pkg.sv
// Shared types and constants for the line pixel generator.
// No dependencies.
package bresln_pkg;

	localparam int CRD_MAX = 6;
	localparam int ERR_W   = CRD_MAX + 3;
	localparam int COLOR_W = 32;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_HORIZ = 2'd1;
	localparam logic [1:0] MODE_VERT  = 2'd2;
	localparam logic [1:0] MODE_DIAG  = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic               steep;
		logic               dir;
		logic [CRD_MAX-1:0] x0;
		logic [CRD_MAX-1:0] y0;
		logic [CRD_MAX-1:0] count;
		logic [ERR_W-1:0]   err0;
		logic [ERR_W-1:0]   inc_pos;
		logic [ERR_W-1:0]   inc_neg;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic load;
	} stat_t;

endpackage

FILE: hdl/bresenham_line_pixels.sv
// Line pixel generator: turns a two-point line request into a stream of
// pixel coordinates with color. A request is checked and set up in the
// front end in the cycle it is pushed and parked in a two-entry command
// queue, so push is refused only when both entries are taken. The walker
// loads a command when idle and then produces one pixel per cycle, so a
// line of N pixels (N = the larger of |dx| and |dy|) is emitted in order;
// a request with equal end points yields no pixels and never reaches the
// walker. Any cycle in which the result register is full and not popped
// stalls the walker. pixel_color is the foreground color at push time.
// Depends on bresln_pkg, bresln_front, bresln_cmdq, bresln_walk and
// bresenham_line_pixels_assert.svh.
`include "bresenham_line_pixels_assert.svh"

module bresenham_line_pixels #(
	parameter int COORD_BITS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bresln_pkg::COLOR_W-1:0] cfg_wr_data,
	input  logic                           push,
	output logic                           full,
	input  logic [COORD_BITS-1:0]          start_x,
	input  logic [COORD_BITS-1:0]          start_y,
	input  logic [COORD_BITS-1:0]          end_x,
	input  logic [COORD_BITS-1:0]          end_y,
	output logic                           empty,
	input  logic                           pop,
	output logic [COORD_BITS-1:0]          pixel_x,
	output logic [COORD_BITS-1:0]          pixel_y,
	output logic [bresln_pkg::COLOR_W-1:0] pixel_color,
	output logic                           last_pixel
);
	import bresln_pkg::*;

	logic [COLOR_W-1:0] fg_color_q;
	cmd_t               front_cmd, q_cmd;
	logic               front_valid, q_wr, q_take, q_ne;
	logic [1:0]         q_level;
	stat_t              walk_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= '1;
		end else if (cfg_wr_en) begin
			fg_color_q <= cfg_wr_data;
		end
	end

	bresln_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.color    (fg_color_q),
		.cmd      (front_cmd),
		.cmd_valid(front_valid)
	);

	assign q_wr = push && !full && front_valid;

	bresln_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.din      (front_cmd),
		.full     (full),
		.rd       (q_take),
		.dout     (q_cmd),
		.not_empty(q_ne),
		.level    (q_level)
	);

	bresln_walk #(
		.COORD_BITS(COORD_BITS)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (q_cmd),
		.cmd_avail  (q_ne),
		.cmd_take   (q_take),
		.empty      (empty),
		.pop        (pop),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel),
		.stat       (walk_stat)
	);

	`BLP_ASSERT_NOW(a_more_pixels_pending, !empty && !last_pixel, walk_stat.busy, "non-last pixel shown while walker idle")
	`BLP_ASSERT_NEXT(a_cmd_queued, q_wr, q_level != 2'd0, "accepted line lost from command queue")
	`BLP_ASSERT_NOW(a_load_only_idle, walk_stat.load, !walk_stat.busy && q_ne, "walker loaded while busy or from empty queue")

endmodule

FILE: hdl/bresln_front.sv
// Front end: classifies a line request and computes its walk setup.
// Depends on bresln_pkg.
module bresln_front #(
	parameter int COORD_BITS = 6
) (
	input  logic [COORD_BITS-1:0]       start_x,
	input  logic [COORD_BITS-1:0]       start_y,
	input  logic [COORD_BITS-1:0]       end_x,
	input  logic [COORD_BITS-1:0]       end_y,
	input  logic [bresln_pkg::COLOR_W-1:0] color,
	output bresln_pkg::cmd_t            cmd,
	output logic                        cmd_valid
);
	import bresln_pkg::*;

	logic [CRD_MAX-1:0] ax, ay, bx, by;
	logic [CRD_MAX-1:0] adx, ady, major, minor;
	logic               shallow;
	logic [ERR_W-1:0]   minor2, major2;

	always_comb begin
		ax = CRD_MAX'(start_x);
		ay = CRD_MAX'(start_y);
		bx = CRD_MAX'(end_x);
		by = CRD_MAX'(end_y);
		adx = (ax > bx) ? (ax - bx) : (bx - ax);
		ady = (ay > by) ? (ay - by) : (by - ay);
		shallow = (ady <= adx);
		major = shallow ? adx : ady;
		minor = shallow ? ady : adx;
		minor2 = {2'b00, minor, 1'b0};
		major2 = {2'b00, major, 1'b0};

		if (ay == by) begin
			cmd.mode = MODE_HORIZ;
		end else if (ax == bx) begin
			cmd.mode = MODE_VERT;
		end else begin
			cmd.mode = MODE_DIAG;
		end

		cmd.steep = !shallow;
		if (shallow) begin
			// left-most end first, minor axis is y
			cmd.x0  = (ax < bx) ? ax : bx;
			cmd.y0  = (ax < bx) ? ay : by;
			cmd.dir = (ax < bx) ? (by < ay) : (ay < by);
		end else begin
			// top-most end first, minor axis is x
			cmd.x0  = (ay < by) ? ax : bx;
			cmd.y0  = (ay < by) ? ay : by;
			cmd.dir = (ay < by) ? (bx < ax) : (ax < bx);
		end
		cmd.count   = major;
		cmd.err0    = minor2 - {3'b000, major};
		cmd.inc_pos = minor2 - major2;
		cmd.inc_neg = minor2;
		cmd.color   = color;
		cmd_valid   = (major != '0);
	end

endmodule

FILE: hdl/bresln_cmdq.sv
// Two-entry command queue between front end and pixel walker.
// Depends on bresln_pkg.
module bresln_cmdq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  bresln_pkg::cmd_t din,
	output logic             full,
	input  logic             rd,
	output bresln_pkg::cmd_t dout,
	output logic             not_empty,
	output logic [1:0]       level
);
	import bresln_pkg::*;

	cmd_t       head_q, tail_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign level     = cnt_q;
	assign dout      = head_q;
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({do_wr, do_rd})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= din;
				end else begin
					tail_q <= din;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= din;
				end else begin
					head_q <= tail_q;
					tail_q <= din;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

FILE: hdl/bresln_walk.sv
// Pixel walker: steps one pixel per cycle through a queued line command
// while its result-side output register is free or popped. Depends on bresln_pkg.
module bresln_walk #(
	parameter int COORD_BITS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bresln_pkg::cmd_t            cmd,
	input  logic                        cmd_avail,
	output logic                        cmd_take,
	output logic                        empty,
	input  logic                        pop,
	output logic [COORD_BITS-1:0]       pixel_x,
	output logic [COORD_BITS-1:0]       pixel_y,
	output logic [bresln_pkg::COLOR_W-1:0] pixel_color,
	output logic                        last_pixel,
	output bresln_pkg::stat_t           stat
);
	import bresln_pkg::*;

	logic               busy_q, steep_q, dir_q, diag_q;
	logic [CRD_MAX-1:0] x_q, y_q, rem_q;
	logic [ERR_W-1:0]   err_q, incp_q, incn_q;
	logic [COLOR_W-1:0] color_q;

	logic               ov_q, pl_q;
	logic [CRD_MAX-1:0] px_q, py_q;
	logic [COLOR_W-1:0] pc_q;

	logic               load, adv, step_minor;
	logic [CRD_MAX-1:0] minor_x, minor_y, nx, ny;

	assign load     = !busy_q && cmd_avail;
	assign cmd_take = load;
	assign adv      = busy_q && (!ov_q || pop);

	always_comb begin
		step_minor = diag_q && !err_q[ERR_W-1];
		minor_x = dir_q ? (x_q - CRD_MAX'(1)) : (x_q + CRD_MAX'(1));
		minor_y = dir_q ? (y_q - CRD_MAX'(1)) : (y_q + CRD_MAX'(1));
		if (steep_q) begin
			ny = y_q + CRD_MAX'(1);
			nx = step_minor ? minor_x : x_q;
		end else begin
			nx = x_q + CRD_MAX'(1);
			ny = step_minor ? minor_y : y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (adv && (rem_q == CRD_MAX'(1))) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q     <= cmd.x0;
			y_q     <= cmd.y0;
			rem_q   <= cmd.count;
			err_q   <= cmd.err0;
			incp_q  <= cmd.inc_pos;
			incn_q  <= cmd.inc_neg;
			steep_q <= cmd.steep;
			dir_q   <= cmd.dir;
			diag_q  <= (cmd.mode == MODE_DIAG);
			color_q <= cmd.color;
		end else if (adv) begin
			x_q   <= nx;
			y_q   <= ny;
			rem_q <= rem_q - CRD_MAX'(1);
			err_q <= err_q + (err_q[ERR_W-1] ? incn_q : incp_q);
		end
		if (adv) begin
			px_q <= x_q;
			py_q <= y_q;
			pc_q <= color_q;
			pl_q <= (rem_q == CRD_MAX'(1));
		end
	end

	assign empty       = !ov_q;
	assign pixel_x     = px_q[COORD_BITS-1:0];
	assign pixel_y     = py_q[COORD_BITS-1:0];
	assign pixel_color = pc_q;
	assign last_pixel  = pl_q;
	assign stat.busy   = busy_q;
	assign stat.load   = load;

endmodule
